>>> hw/rtl/i2cmbs_pkg.sv
`default_nettype none

package i2cmbs_pkg;

  // Command codes on func; code zero is a bus tick, which is also the idle operation code
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_WAIT  = 3'd5,
    OP_ACK   = 3'd6,
    OP_NACK  = 3'd7
  } op_e;

  localparam int unsigned TimeoutWidth = 8;
  localparam logic [TimeoutWidth-1:0] AckTimeoutReset = 8'd250;
  localparam int unsigned ByteWidth = 8;
  localparam logic [2:0] LastBit = 3'd7;

endpackage

`default_nettype wire

>>> hw/rtl/i2c_master_bit_sequencer_unit.sv
`default_nettype none

// I2C master pin sequencer. While idle it takes one command (start, stop, write byte, read
// byte, wait for ACK, send ACK, send NACK) and every later transfer with func zero is one bus
// tick that moves SCL, SDA and the SDA direction one step. Each input transfer yields exactly
// one result transfer carrying the pin levels, busy, done, the last received byte, the
// acknowledge failure flag and a rejected flag for commands given while busy. A transfer is
// taken every clock while the result register is empty or being drained: the sequencer state
// and the result register update together in the cycle of acceptance, so the result appears
// in the following cycle. The ack_timeout register (reset 250) sets how many high SDA polls
// wait-ack tolerates before it issues a stop and flags failure.
module i2c_master_bit_sequencer_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [i2cmbs_pkg::TimeoutWidth-1:0]  ack_timeout_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [2:0]                           func_i,
  input  wire logic [i2cmbs_pkg::ByteWidth-1:0]     tx_byte_i,
  input  wire logic                                 send_ack_i,
  input  wire logic                                 sda_in_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      scl_level_o,
  output logic                                      sda_level_o,
  output logic                                      sda_is_output_o,
  output logic                                      busy_res_o,
  output logic                                      done_res_o,
  output logic [i2cmbs_pkg::ByteWidth-1:0]          rx_byte_o,
  output logic                                      ack_failed_o,
  output logic                                      rejected_o
);
  import i2cmbs_pkg::*;

  logic [TimeoutWidth-1:0] timeout_q;
  op_e                     op_q, op_d, func_op;
  logic [2:0]              bit_q, bit_d;
  logic [1:0]              phase_q, phase_d;
  logic [ByteWidth-1:0]    shift_q, shift_d;
  logic [TimeoutWidth-1:0] wait_q, wait_d;
  logic                    scl_q, scl_d, sda_q, sda_d, dir_q, dir_d;
  logic                    ackc_q, ackc_d, fail_q, fail_d;
  logic [ByteWidth-1:0]    rx_q, rx_d;
  logic                    done_d, rej_d;
  logic [TimeoutWidth:0]   wait_inc;
  logic                    accept;

  logic                    out_valid_q;
  logic                    o_scl_q, o_sda_q, o_dir_q, o_busy_q, o_done_q, o_fail_q, o_rej_q;
  logic [ByteWidth-1:0]    o_rx_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign func_op     = op_e'(func_i);
  assign wait_inc    = {1'b0, wait_q} + 1'b1;

  // Compute the next sequencer state for one command or tick
  always_comb begin
    op_d    = op_q;
    bit_d   = bit_q;
    phase_d = phase_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    dir_d   = dir_q;
    ackc_d  = ackc_q;
    fail_d  = fail_q;
    rx_d    = rx_q;
    done_d  = 1'b0;
    rej_d   = 1'b0;
    if (func_op == OP_IDLE) begin
      // Advance the running sequence by one tick
      case (op_q)
        OP_START: begin
          if (phase_q == 2'd0) begin
            sda_d   = 1'b0;
            phase_d = 2'd1;
          end else begin
            scl_d  = 1'b0;
            done_d = 1'b1;
          end
        end
        OP_STOP: begin
          if (phase_q == 2'd0) begin
            scl_d   = 1'b1;
            phase_d = 2'd1;
          end else begin
            sda_d  = 1'b1;
            done_d = 1'b1;
          end
        end
        OP_ACK, OP_NACK: begin
          if (phase_q == 2'd0) begin
            scl_d   = 1'b1;
            phase_d = 2'd1;
          end else begin
            scl_d  = 1'b0;
            done_d = 1'b1;
          end
        end
        OP_WRITE: begin
          if (phase_q == 2'd0) begin
            scl_d   = 1'b1;
            phase_d = 2'd1;
          end else if (phase_q == 2'd1) begin
            scl_d   = 1'b0;
            phase_d = 2'd2;
          end else if (bit_q == LastBit) begin
            done_d = 1'b1;
          end else begin
            bit_d   = bit_q + 3'd1;
            sda_d   = shift_q[ByteWidth-1];
            shift_d = {shift_q[ByteWidth-2:0], 1'b0};
            phase_d = 2'd0;
          end
        end
        OP_READ: begin
          if (phase_q == 2'd0) begin
            scl_d   = 1'b1;
            shift_d = {shift_q[ByteWidth-2:0], sda_in_i};
            phase_d = 2'd1;
          end else if (bit_q != LastBit) begin
            bit_d   = bit_q + 3'd1;
            scl_d   = 1'b0;
            phase_d = 2'd0;
          end else begin
            // Hand over to the acknowledge tail
            rx_d    = shift_q;
            scl_d   = 1'b0;
            dir_d   = 1'b1;
            sda_d   = !ackc_q;
            op_d    = ackc_q ? OP_ACK : OP_NACK;
            phase_d = 2'd0;
          end
        end
        OP_WAIT: begin
          if (phase_q == 2'd0) begin
            scl_d   = 1'b1;
            phase_d = 2'd1;
          end else if (!sda_in_i) begin
            scl_d  = 1'b0;
            done_d = 1'b1;
          end else if (wait_inc > {1'b0, timeout_q}) begin
            // Give up and issue a stop
            fail_d  = 1'b1;
            dir_d   = 1'b1;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            op_d    = OP_STOP;
            phase_d = 2'd0;
          end else begin
            wait_d = wait_inc[TimeoutWidth-1:0];
          end
        end
        default: begin
        end
      endcase
      if (done_d) begin
        op_d    = OP_IDLE;
        phase_d = 2'd0;
      end
    end else if (op_q != OP_IDLE) begin
      rej_d = 1'b1;
    end else begin
      // Start a new command from idle
      fail_d  = 1'b0;
      phase_d = 2'd0;
      bit_d   = 3'd0;
      wait_d  = '0;
      op_d    = func_op;
      case (func_op)
        OP_START: begin
          dir_d = 1'b1;
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
        OP_STOP: begin
          dir_d = 1'b1;
          scl_d = 1'b0;
          sda_d = 1'b0;
        end
        OP_WRITE: begin
          dir_d   = 1'b1;
          scl_d   = 1'b0;
          sda_d   = tx_byte_i[ByteWidth-1];
          shift_d = {tx_byte_i[ByteWidth-2:0], 1'b0};
        end
        OP_READ: begin
          dir_d   = 1'b0;
          scl_d   = 1'b0;
          shift_d = '0;
          ackc_d  = send_ack_i;
        end
        OP_WAIT: begin
          dir_d = 1'b0;
          sda_d = 1'b1;
        end
        default: begin
          scl_d = 1'b0;
          dir_d = 1'b1;
          sda_d = (func_op != OP_ACK);
        end
      endcase
    end
  end

  // Hold the timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= AckTimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= ack_timeout_i;
    end
  end

  // Update sequencer state on each accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_IDLE;
      bit_q   <= '0;
      phase_q <= '0;
      shift_q <= '0;
      wait_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      dir_q   <= 1'b1;
      ackc_q  <= 1'b0;
      fail_q  <= 1'b0;
      rx_q    <= '0;
    end else if (accept) begin
      op_q    <= op_d;
      bit_q   <= bit_d;
      phase_q <= phase_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      dir_q   <= dir_d;
      ackc_q  <= ackc_d;
      fail_q  <= fail_d;
      rx_q    <= rx_d;
    end
  end

  // Track the result register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      o_scl_q  <= scl_d;
      o_sda_q  <= sda_d;
      o_dir_q  <= dir_d;
      o_busy_q <= (op_d != OP_IDLE);
      o_done_q <= done_d;
      o_rx_q   <= rx_d;
      o_fail_q <= fail_d;
      o_rej_q  <= rej_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_level_o     = o_scl_q;
  assign sda_level_o     = o_sda_q;
  assign sda_is_output_o = o_dir_q;
  assign busy_res_o      = o_busy_q;
  assign done_res_o      = o_done_q;
  assign rx_byte_o       = o_rx_q;
  assign ack_failed_o    = o_fail_q;
  assign rejected_o      = o_rej_q;

endmodule

`default_nettype wire

>>> hw/rtl/i2cmbs_checker.sv
`default_nettype none

module i2cmbs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       busy_res_o,
  input wire logic       done_res_o,
  input wire logic       rejected_o,
  input wire logic [7:0] rx_byte_o
);

  // A finished sequence leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  // A rejected command only happens while a sequence runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o && !done_res_o)
    else $error("rejected result without a running sequence");

  // An empty result register never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_byte_o))
    else $error("stalled result dropped or changed");

  // An accepted transfer always yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transfer produced no result");

endmodule

bind i2c_master_bit_sequencer_unit i2cmbs_checker u_i2cmbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .rejected_o  (rejected_o),
  .rx_byte_o   (rx_byte_o)
);

`default_nettype wire

>>> dv/i2cmbs_tb_pkg.sv
`timescale 1ns / 1ps

package i2cmbs_tb_pkg;

  import i2cmbs_pkg::*;

  // Pin levels and flags carried by one result transfer
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       sda_oe;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack_fail;
    logic       rejected;
  } pin_state_t;

  // Tracks the bus sequencer and queues the pin state due for each accepted transfer
  class pin_scoreboard;
    op_e        cur_op;
    logic [3:0] bit_cnt;
    logic [1:0] phase;
    logic [7:0] shifter;
    logic [7:0] poll_cnt;
    logic [7:0] rx_last;
    logic [7:0] timeout_lim;
    logic       scl_q;
    logic       sda_q;
    logic       sda_oe_q;
    logic       answer_ack;
    logic       ack_fail;
    pin_state_t pending[$];
    int         errors;

    function new();
      cur_op      = OP_IDLE;
      bit_cnt     = '0;
      phase       = '0;
      shifter     = '0;
      poll_cnt    = '0;
      rx_last     = '0;
      timeout_lim = AckTimeoutReset;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      sda_oe_q    = 1'b1;
      answer_ack  = 1'b0;
      ack_fail    = 1'b0;
      errors      = 0;
    endfunction

    function void set_ack_timeout(logic [7:0] value);
      timeout_lim = value;
    endfunction

    // Pull SCL and SDA low, then release them in stop order
    function void open_stop();
      sda_oe_q = 1'b1;
      scl_q    = 1'b0;
      sda_q    = 1'b0;
      cur_op   = OP_STOP;
      phase    = '0;
    endfunction

    // Drive the ninth bit: low for ACK, high for NACK
    function void open_answer(op_e op);
      scl_q    = 1'b0;
      sda_oe_q = 1'b1;
      sda_q    = (op != OP_ACK);
      cur_op   = op;
      phase    = '0;
    endfunction

    function void take_command(op_e f, logic [7:0] tx, logic ack);
      ack_fail = 1'b0;
      phase    = '0;
      bit_cnt  = '0;
      poll_cnt = '0;
      case (f)
        OP_START: begin
          sda_oe_q = 1'b1;
          sda_q    = 1'b1;
          scl_q    = 1'b1;
          cur_op   = OP_START;
        end
        OP_STOP: open_stop();
        OP_WRITE: begin
          sda_oe_q = 1'b1;
          scl_q    = 1'b0;
          sda_q    = tx[7];
          shifter  = {tx[6:0], 1'b0};
          cur_op   = OP_WRITE;
        end
        OP_READ: begin
          sda_oe_q   = 1'b0;
          scl_q      = 1'b0;
          shifter    = '0;
          answer_ack = ack;
          cur_op     = OP_READ;
        end
        OP_WAIT: begin
          sda_oe_q = 1'b0;
          sda_q    = 1'b1;
          cur_op   = OP_WAIT;
        end
        default: open_answer(f);
      endcase
    endfunction

    // Advance one bus tick; return 1 when the running sequence finishes
    function bit bus_tick(logic sda_in);
      case (cur_op)
        OP_START: begin
          if (phase == 2'd0) begin
            sda_q = 1'b0;
            phase = 2'd1;
            return 1'b0;
          end
          scl_q = 1'b0;
          return 1'b1;
        end
        OP_STOP: begin
          if (phase == 2'd0) begin
            scl_q = 1'b1;
            phase = 2'd1;
            return 1'b0;
          end
          sda_q = 1'b1;
          return 1'b1;
        end
        OP_ACK, OP_NACK: begin
          if (phase == 2'd0) begin
            scl_q = 1'b1;
            phase = 2'd1;
            return 1'b0;
          end
          scl_q = 1'b0;
          return 1'b1;
        end
        OP_WRITE: begin
          if (phase == 2'd0) begin
            scl_q = 1'b1;
            phase = 2'd1;
            return 1'b0;
          end
          if (phase == 2'd1) begin
            scl_q = 1'b0;
            phase = 2'd2;
            return 1'b0;
          end
          if (bit_cnt >= {1'b0, LastBit}) return 1'b1;
          bit_cnt = bit_cnt + 4'd1;
          sda_q   = shifter[7];
          shifter = {shifter[6:0], 1'b0};
          phase   = 2'd0;
          return 1'b0;
        end
        OP_READ: begin
          // sample SDA on the tick that raises SCL
          if (phase == 2'd0) begin
            scl_q   = 1'b1;
            shifter = {shifter[6:0], sda_in};
            phase   = 2'd1;
            return 1'b0;
          end
          if (bit_cnt < {1'b0, LastBit}) begin
            bit_cnt = bit_cnt + 4'd1;
            scl_q   = 1'b0;
            phase   = 2'd0;
            return 1'b0;
          end
          // byte complete: hold it and go on with the answer bit
          rx_last = shifter;
          if (answer_ack) open_answer(OP_ACK);
          else open_answer(OP_NACK);
          return 1'b0;
        end
        OP_WAIT: begin
          if (phase == 2'd0) begin
            scl_q = 1'b1;
            phase = 2'd1;
            return 1'b0;
          end
          if (!sda_in) begin
            scl_q = 1'b0;
            return 1'b1;
          end
          // count compared without wrap: a limit of 255 allows 255 high polls
          if (int'(poll_cnt) + 1 > int'(timeout_lim)) begin
            ack_fail = 1'b1;
            open_stop();
            return 1'b0;
          end
          poll_cnt = poll_cnt + 8'd1;
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Note one accepted input transfer and queue the pin state it causes
    function void accept_item(op_e f, logic [7:0] tx, logic ack, logic sda_in);
      pin_state_t due;
      logic       finished;
      logic       rej;
      finished = 1'b0;
      rej      = 1'b0;
      if (f == OP_IDLE) begin
        if (cur_op != OP_IDLE && bus_tick(sda_in)) begin
          cur_op   = OP_IDLE;
          phase    = '0;
          finished = 1'b1;
        end
      end else if (cur_op != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        take_command(f, tx, ack);
      end
      due.scl      = scl_q;
      due.sda      = sda_q;
      due.sda_oe   = sda_oe_q;
      due.busy     = (cur_op != OP_IDLE);
      due.done     = finished;
      due.rx       = rx_last;
      due.ack_fail = ack_fail;
      due.rejected = rej;
      pending.push_back(due);
    endfunction

    function void diff(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest queued pin state
    function void check_pins(pin_state_t got);
      pin_state_t due;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      due = pending.pop_front();
      diff("scl_level", due.scl, got.scl);
      diff("sda_level", due.sda, got.sda);
      diff("sda_is_output", due.sda_oe, got.sda_oe);
      diff("busy_res", due.busy, got.busy);
      diff("done_res", due.done, got.done);
      diff("rx_byte", due.rx, got.rx);
      diff("ack_failed", due.ack_fail, got.ack_fail);
      diff("rejected", due.rejected, got.rejected);
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import i2cmbs_pkg::*;
  import i2cmbs_tb_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int NeverLow   = 1 << 20;
  localparam int PhaseItems = 170;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid   = 1'b0;
  logic [7:0] ack_timeout = 8'd0;
  logic       in_valid    = 1'b0;
  logic [2:0] func        = OP_IDLE;
  logic [7:0] tx_byte     = 8'd0;
  logic       send_ack    = 1'b0;
  logic       sda_in      = 1'b0;
  logic       out_ready   = 1'b0;

  logic       cfg_ready;
  logic       in_ready;
  logic       out_valid;
  logic       scl_level;
  logic       sda_level;
  logic       sda_is_output;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;
  logic       rejected;

  pin_scoreboard sb = new();

  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;
  int stall_left  = 0;
  int cycles      = 0;

  i2c_master_bit_sequencer_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .ack_timeout_i   (ack_timeout),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .tx_byte_i       (tx_byte),
    .send_ack_i      (send_ack),
    .sda_in_i        (sda_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .scl_level_o     (scl_level),
    .sda_level_o     (sda_level),
    .sda_is_output_o (sda_is_output),
    .busy_res_o      (busy_res),
    .done_res_o      (done_res),
    .rx_byte_o       (rx_byte),
    .ack_failed_o    (ack_failed),
    .rejected_o      (rejected)
  );

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 24);
  endfunction

  // Stall the result side at random, with quiet stretches
  always @(posedge clk_i) begin
    if (cycles % 200 == 0) sink_steady <= ($urandom_range(0, 2) == 0);
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 99) < 30) stall_left <= idle_gap();
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    pin_state_t got;
    if (rst_ni && out_valid && out_ready) begin
      got.scl      = scl_level;
      got.sda      = sda_level;
      got.sda_oe   = sda_is_output;
      got.busy     = busy_res;
      got.done     = done_res;
      got.rx       = rx_byte;
      got.ack_fail = ack_failed;
      got.rejected = rejected;
      sb.check_pins(got);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Hold one input transfer until it is accepted, then note it
  task automatic send_bus_item(input logic [2:0] f, input logic [7:0] tx, input logic ack,
                               input logic sda);
    int gap;
    gap = src_steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func     <= f;
    tx_byte  <= tx;
    send_ack <= ack;
    sda_in   <= sda;
    do @(posedge clk_i); while (!in_ready);
    sb.accept_item(op_e'(f), tx, ack, sda);
  endtask

  // Write the timeout register while the sequencer is idle
  task automatic write_ack_timeout(input logic [7:0] value);
    cfg_valid   <= 1'b1;
    ack_timeout <= value;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_ack_timeout(value);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every pending result to drain
  task automatic settle_bus();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Wait for ACK with SDA held high until the timeout stop completes
  task automatic timeout_wait_ack();
    send_bus_item(OP_WAIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    while (sb.cur_op != OP_IDLE)
      send_bus_item(OP_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Short directed pass over start, stop, ACK, NACK and wait-ack, a rejected write and idle ticks
  task automatic run_directed();
    send_bus_item(OP_IDLE, 8'hFF, 1'b1, 1'b1);
    send_bus_item(OP_START, 8'h00, 1'b0, 1'b0);
    send_bus_item(OP_WRITE, 8'hFF, 1'b1, 1'b1);
    send_bus_item(OP_IDLE, 8'h00, 1'b0, 1'b0);
    send_bus_item(OP_IDLE, 8'hFF, 1'b1, 1'b1);
    send_bus_item(OP_STOP, 8'h00, 1'b0, 1'b0);
    send_bus_item(OP_IDLE, 8'h00, 1'b0, 1'b0);
    send_bus_item(OP_IDLE, 8'h00, 1'b0, 1'b0);
    send_bus_item(OP_ACK, 8'h00, 1'b0, 1'b1);
    send_bus_item(OP_IDLE, 8'h00, 1'b0, 1'b1);
    send_bus_item(OP_IDLE, 8'h00, 1'b0, 1'b1);
    send_bus_item(OP_NACK, 8'hFF, 1'b1, 1'b0);
    send_bus_item(OP_IDLE, 8'hFF, 1'b1, 1'b0);
    send_bus_item(OP_IDLE, 8'hFF, 1'b1, 1'b0);
    send_bus_item(OP_WAIT, 8'h00, 1'b0, 1'b1);
    send_bus_item(OP_IDLE, 8'h00, 1'b0, 1'b1);
    send_bus_item(OP_IDLE, 8'h00, 1'b0, 1'b1);
    send_bus_item(OP_IDLE, 8'h00, 1'b0, 1'b0);
  endtask

  // Random command sequences, each followed by ticks until it completes
  task automatic run_bus_traffic(input int n_items);
    int         sent;
    int         polls;
    int         low_after;
    logic [2:0] f;
    logic [7:0] tx;
    logic       sda;
    sent      = 0;
    polls     = 0;
    low_after = 0;
    while (sent < n_items || sb.cur_op != OP_IDLE) begin
      if ($urandom_range(0, 39) == 0) src_steady = ~src_steady;
      tx  = 8'($urandom_range(0, 255));
      sda = 1'($urandom_range(0, 1));
      f   = OP_IDLE;
      if (sb.cur_op == OP_IDLE) begin
        // mostly a new command, sometimes a tick that does nothing
        if ($urandom_range(0, 9) != 0) begin
          f = 3'($urandom_range(1, 7));
          case ($urandom_range(0, 9))
            0: tx = 8'h00;
            1: tx = 8'hFF;
            default: ;
          endcase
          if (f == OP_WAIT) begin
            polls = 0;
            if ($urandom_range(0, (sb.timeout_lim <= 8'd8) ? 2 : 11) == 0) low_after = NeverLow;
            else low_after = $urandom_range(0, 6);
          end
        end
      end else if (sent < n_items && $urandom_range(0, 99) < 6) begin
        // command while busy: must be rejected
        f = 3'($urandom_range(1, 7));
      end else if (sb.cur_op == OP_WAIT) begin
        sda = (polls >= low_after) ? 1'b0 : 1'b1;
        if (low_after != NeverLow && $urandom_range(0, 9) == 0) sda = ~sda;
        polls++;
      end
      send_bus_item(f, tx, 1'($urandom_range(0, 1)), sda);
      sent++;
    end
  endtask

  initial begin
    logic [7:0] lim_plan[6];
    lim_plan = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0, 8'd250};
    lim_plan[4] = 8'($urandom_range(4, 254));

    // hold reset, release at a clock edge
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the timeout first
    run_directed();
    run_bus_traffic(PhaseItems);
    settle_bus();

    foreach (lim_plan[i]) begin
      write_ack_timeout(lim_plan[i]);
      if (lim_plan[i] == 8'd0 || lim_plan[i] == 8'd255) timeout_wait_ack();
      run_bus_traffic(PhaseItems);
      settle_bus();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
